// File: rtl/sti_pkg.sv
// Package for the sorted table block: codes, field widths and the cell control word.
// Used by sti_cell, the top level and the testbench files; depends on nothing else.
package sti_pkg;

    // Default number of table slots.
    localparam int DEFAULT_DEPTH = 128;

    // Field widths at the ports.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 8;
    localparam int ODATA_W  = 16;

    // Operation kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Control word broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                       compare;
        logic                       scan;
        logic                       apply;
        logic                       kind;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// File: rtl/sti_cell.sv
// One slot of the sorted table: holds an entry, compares it with the item value,
// and trades entries and marks with its two neighbors. Depends on sti_pkg.
module sti_cell #(
    parameter int CW  = 8,
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sti_pkg::cell_ctrl_t               ctrl,
    input  logic [CW-1:0]                     count,
    input  logic signed [sti_pkg::VALUE_W-1:0] prev_entry,
    input  logic                              prev_flag,
    input  logic                              prev_shift,
    input  logic signed [sti_pkg::VALUE_W-1:0] next_entry,
    input  logic                              next_mark,
    output logic signed [sti_pkg::VALUE_W-1:0] entry,
    output logic                              flag,
    output logic                              shift,
    output logic                              mark
);
    import sti_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic                      mark_reg;
    logic                      shift_reg;
    logic                      valid;
    logic                      eq;
    logic                      gt;
    logic                      lt;

    // A slot holds a live entry when it lies below the count.
    assign valid = count > CW'(IDX);
    assign eq    = valid && (entry_reg == ctrl.value);
    assign gt    = !valid || (entry_reg > ctrl.value);
    assign lt    = valid && (entry_reg < ctrl.value);

    // Insert looks for the first slot above the value, delete for the first equal slot.
    assign flag = (ctrl.kind == KIND_DELETE) ? eq : gt;

    // Marks are captured at compare time and then walk down toward slot zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= 1'b0;
            shift_reg <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            mark_reg  <= flag && !prev_flag;
            shift_reg <= (ctrl.kind == KIND_DELETE) ? (valid && !lt) : gt;
        end
        else if (ctrl.scan)
        begin
            mark_reg <= next_mark;
        end
    end

    // Insert opens a gap by moving entries up; delete closes one by moving them down.
    always_ff @(posedge clk)
    begin
        if (ctrl.apply && shift_reg)
        begin
            if (ctrl.kind == KIND_INSERT)
            begin
                entry_reg <= prev_shift ? prev_entry : ctrl.value;
            end
            else
            begin
                entry_reg <= next_entry;
            end
        end
    end

    assign entry = entry_reg;
    assign shift = shift_reg;
    assign mark  = mark_reg;

endmodule

// File: rtl/sorted_table_insert_delete_top.sv
// Top level of the sorted table: a row of sti_cell slots, the sequencer that drives
// them, the live count and the result register. Depends on sti_pkg and sti_cell.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser: kind; tdata: value
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: position, count_after
//
// One item at a time. An insert or delete that finds its slot goes through the compare,
// the scan steps of the mark walking down the cell row, the shift, and the result load.
// A delete with no match scans up to the count and then goes to the result load; an
// insert into a full table goes from the compare straight to the result load.
// Reset empties the table at once. A stalled result holds; the next item is taken
// meanwhile and waits before its result load until the register is free.
module sorted_table_insert_delete_top #(
    parameter int TABLE_DEPTH = sti_pkg::DEFAULT_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [0:0]                    s_tuser,   // [0] kind
    input  logic [sti_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sti_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic [sti_pkg::ODATA_W-1:0]   m_tdata    // [6:0] position, [14:7] count_after
);
    import sti_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic                      kind_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [CW-1:0]             pos_reg, pos_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [CW-1:0]             rpos_reg, rpos_next;
    logic                      m_tvalid_reg;
    logic [STATUS_W-1:0]       m_tuser_reg;
    logic [ODATA_W-1:0]        m_tdata_reg;
    logic                      accept;
    logic                      out_free;
    logic                      out_load;
    cell_ctrl_t                ctrl;

    logic signed [VALUE_W-1:0] entry_w [TABLE_DEPTH];
    logic                      flag_w  [TABLE_DEPTH];
    logic                      shift_w [TABLE_DEPTH];
    logic                      mark_w  [TABLE_DEPTH];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_DONE) && out_free;

    // Control word shared by all cells.
    assign ctrl.compare = (state_reg == S_CMP);
    assign ctrl.scan    = (state_reg == S_SCAN);
    assign ctrl.apply   = (state_reg == S_APPLY);
    assign ctrl.kind    = kind_reg;
    assign ctrl.value   = value_reg;

    // Row of cells wired to their neighbors; the end cells tie off the missing side.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] prev_entry;
        logic                      prev_flag;
        logic                      prev_shift;
        logic signed [VALUE_W-1:0] next_entry;
        logic                      next_mark;

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_flag  = 1'b0;
            assign prev_shift = 1'b0;
        end
        else
        begin : g_inner
            assign prev_entry = entry_w[i-1];
            assign prev_flag  = flag_w[i-1];
            assign prev_shift = shift_w[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign next_entry = entry_w[i];
            assign next_mark  = 1'b0;
        end
        else
        begin : g_body
            assign next_entry = entry_w[i+1];
            assign next_mark  = mark_w[i+1];
        end

        sti_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (cnt_reg),
            .prev_entry (prev_entry),
            .prev_flag  (prev_flag),
            .prev_shift (prev_shift),
            .next_entry (next_entry),
            .next_mark  (next_mark),
            .entry      (entry_w[i]),
            .flag       (flag_w[i]),
            .shift      (shift_w[i]),
            .mark       (mark_w[i])
        );
    end

    // Sequencer: compare, walk mark to slot zero, shift, report; full/miss report early.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        rpos_next   = rpos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                pos_next = '0;
                if ((kind_reg == KIND_INSERT) && (cnt_reg == CW'(TABLE_DEPTH)))
                begin
                    status_next = ST_FULL;
                    rpos_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (mark_w[0])
                begin
                    status_next = ST_DONE;
                    rpos_next   = pos_reg;
                    state_next  = S_APPLY;
                end
                else if (pos_reg == cnt_reg)
                begin
                    status_next = ST_MISSING;
                    rpos_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_APPLY:
            begin
                cnt_next   = (kind_reg == KIND_INSERT) ? cnt_reg + 1'b1 : cnt_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= s_tuser[0];
            value_reg <= s_tdata;
        end
        pos_reg    <= pos_next;
        status_reg <= status_next;
        rpos_reg   <= rpos_next;
        if (out_load)
        begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {1'b0, COUNT_W'(cnt_reg), POS_W'(rpos_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // The count never passes the table depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // The scan position never runs past the live count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (pos_reg <= cnt_reg))
        else $error("scan position beyond count");

    // A shift step always changes the count (the sequencer moves it by one).
    a_apply_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (cnt_reg != $past(cnt_reg)))
        else $error("shift step left the count unchanged");

    // A full status is only reported when the table is at capacity.
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (status_reg == ST_FULL)) |-> (cnt_reg == CW'(TABLE_DEPTH)))
        else $error("full status with free slots");

    // A finished item waiting on the result register never loses it.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !out_free) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

// File: tb/sorted_table_checker.sv
// Checker for the sorted table block: watches both stream channels, keeps a shadow table.
// Predicts each result word and compares it field by field. Depends on sti_pkg only.
module sorted_table_checker #(
    parameter int TABLE_DEPTH = sti_pkg::DEFAULT_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [0:0]                    s_tuser,   // [0] kind
    input  logic [sti_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sti_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    input  logic [sti_pkg::ODATA_W-1:0]   m_tdata,   // [6:0] position, [14:7] count_after
    output int                            fail_count,
    output int                            pending_count,
    output int                            placed_count,
    output int                            removed_count,
    output int                            full_count,
    output int                            missing_count,
    output int                            peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    import sti_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count_after;
    } table_result_t;

    // Shadow copy of the table contents and its live count.
    logic signed [VALUE_W-1:0] shadow_slots [TABLE_DEPTH];
    int                        shadow_count;
    table_result_t             pending_results [$];

    initial
    begin
        shadow_count  = 0;
        fail_count    = 0;
        pending_count = 0;
        placed_count  = 0;
        removed_count = 0;
        full_count    = 0;
        missing_count = 0;
        peak_fill     = 0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0d ns: %s", $time, msg);
        fail_count++;
    endtask

    // Apply one insert or delete to the shadow table and return the word it must produce.
    function automatic table_result_t apply_table_update(input logic kind,
                                                         input logic signed [VALUE_W-1:0] value);
        table_result_t res;
        int            p;
        int            k;
        res.status      = ST_DONE;
        res.position    = '0;
        res.count_after = shadow_count[COUNT_W-1:0];
        p = 0;
        if (kind == KIND_INSERT)
        begin
            if (shadow_count >= TABLE_DEPTH)
            begin
                res.status = ST_FULL;
                full_count++;
                return res;
            end
            // New value goes after every entry that is less than or equal to it.
            while (p < shadow_count && shadow_slots[p] <= value)
            begin
                p++;
            end
            for (k = shadow_count; k > p; k--)
            begin
                shadow_slots[k] = shadow_slots[k - 1];
            end
            shadow_slots[p] = value;
            shadow_count++;
            placed_count++;
        end
        else
        begin
            // Lowest-indexed equal entry is the one removed.
            while (p < shadow_count && shadow_slots[p] != value)
            begin
                p++;
            end
            if (p >= shadow_count)
            begin
                res.status = ST_MISSING;
                missing_count++;
                return res;
            end
            for (k = p; k + 1 < shadow_count; k++)
            begin
                shadow_slots[k] = shadow_slots[k + 1];
            end
            shadow_count--;
            removed_count++;
        end
        res.position    = p[POS_W-1:0];
        res.count_after = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // Predict on every accepted input word, compare on every accepted result word.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(apply_table_update(s_tuser[0], $signed(s_tdata)));
                if (shadow_count > peak_fill)
                begin
                    peak_fill = shadow_count;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word 0x%0h/0x%0h with nothing expected",
                                              m_tuser, m_tdata));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        report_mismatch($sformatf("status expected %0d, got %0d",
                                                  want.status, m_tuser));
                    end
                    if (m_tdata[POS_W-1:0] !== want.position)
                    begin
                        report_mismatch($sformatf("position expected %0d, got %0d",
                                                  want.position, m_tdata[POS_W-1:0]));
                    end
                    if (m_tdata[POS_W+COUNT_W-1:POS_W] !== want.count_after)
                    begin
                        report_mismatch($sformatf("count_after expected %0d, got %0d",
                                                  want.count_after,
                                                  m_tdata[POS_W+COUNT_W-1:POS_W]));
                    end
                    if (m_tdata[ODATA_W-1:POS_W+COUNT_W] !== '0)
                    begin
                        report_mismatch($sformatf("padding bits of tdata not zero: 0x%0h",
                                                  m_tdata));
                    end
                end
            end
            pending_count = pending_results.size();
        end
    end

endmodule

// File: tb/sorted_table_insert_delete_top_tb.sv
// Testbench top for the sorted table: clock, reset, stimulus, result-side stalls and verdict.
// Depends on sti_pkg, sorted_table_insert_delete_top and sorted_table_checker.
module sorted_table_insert_delete_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sti_pkg::*;

    localparam int DEPTH        = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 300;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [0:0]            s_tuser  = KIND_INSERT;   // [0] kind
    logic [VALUE_W-1:0]    s_tdata  = '0;            // [31:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [STATUS_W-1:0]   m_tuser;                  // [1:0] status
    logic [ODATA_W-1:0]    m_tdata;                  // [6:0] position, [14:7] count_after

    int fail_count;
    int pending_count;
    int placed_count;
    int removed_count;
    int full_count;
    int missing_count;
    int peak_fill;

    int send_idle_pct = 18;
    int recv_idle_pct = 60;
    int items_sent    = 0;
    int cycle_count   = 0;

    // Values the stimulus believes are in the table, used to aim deletes at hits.
    logic [VALUE_W-1:0] live_values [$];

    sorted_table_insert_delete_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    sorted_table_checker #(
        .TABLE_DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tuser       (m_tuser),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .placed_count  (placed_count),
        .removed_count (removed_count),
        .full_count    (full_count),
        .missing_count (missing_count),
        .peak_fill     (peak_fill)
    );

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Random back-pressure on the result channel.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("status: fail");
            $finish;
        end
    end

    // Offer one word, with random idle cycles ahead of it, and hold it until accepted.
    task automatic send_word(input logic kind, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Stop sending until every expected result word has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly small values so equal entries and hits are common, with full-range and extremes.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = $urandom_range(40) - 20;
            5, 6, 7:       v = $urandom;
            8:
            begin
                case ($urandom_range(3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default:       v = $urandom_range(1) ? 32'h8000_0001 : 32'h7FFF_FFFE;
        endcase
        return v;
    endfunction

    // Insert a value and mirror it if the table should have room for it.
    task automatic insert_value(input logic [VALUE_W-1:0] value);
        send_word(KIND_INSERT, value);
        if (live_values.size() < DEPTH)
        begin
            live_values.push_back(value);
        end
    endtask

    // Delete a value believed present, or a miss when the table is thought empty.
    task automatic delete_live_value();
        int idx;
        logic [VALUE_W-1:0] v;
        if (live_values.size() == 0)
        begin
            send_word(KIND_DELETE, pick_value());
        end
        else
        begin
            idx = $urandom_range(live_values.size() - 1);
            v   = live_values[idx];
            live_values.delete(idx);
            send_word(KIND_DELETE, v);
        end
    endtask

    // One run of random traffic: a mixed stretch, a fill past capacity, or a full drain.
    task automatic random_run();
        int len;
        case ($urandom_range(9))
            0, 1:
            begin
                while (live_values.size() < DEPTH)
                begin
                    insert_value(pick_value());
                end
                len = $urandom_range(6, 2);
                repeat (len) insert_value(pick_value());
                // Deletes at a full table, then more inserts to see it fill again.
                repeat (len) delete_live_value();
                repeat (len) insert_value(pick_value());
            end
            2, 3:
            begin
                while (live_values.size() > 0)
                begin
                    delete_live_value();
                end
                len = $urandom_range(3, 1);
                repeat (len) send_word(KIND_DELETE, pick_value());
            end
            default:
            begin
                len = $urandom_range(60, 20);
                repeat (len)
                begin
                    case ($urandom_range(19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: insert_value(pick_value());
                        11, 12, 13, 14, 15, 16, 17:       delete_live_value();
                        default:                          send_word(KIND_DELETE, $urandom);
                    endcase
                end
            end
        endcase
    endtask

    // Directed items, then three idling phases of random runs, then drain and verdict.
    initial
    begin
        int phase;
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Delete on an empty table, extremes, equal values and end-slot deletes.
        send_word(KIND_DELETE, 32'h0000_0000);
        send_word(KIND_INSERT, 32'h8000_0000);
        send_word(KIND_INSERT, 32'h7FFF_FFFF);
        send_word(KIND_INSERT, 32'h0000_0000);
        send_word(KIND_INSERT, 32'hFFFF_FFFF);
        send_word(KIND_INSERT, 32'h0000_0005);
        send_word(KIND_INSERT, 32'h0000_0005);
        send_word(KIND_INSERT, 32'h0000_0005);
        send_word(KIND_DELETE, 32'h0000_0005);
        send_word(KIND_DELETE, 32'h0000_0007);
        send_word(KIND_DELETE, 32'h7FFF_FFFF);
        send_word(KIND_DELETE, 32'h8000_0000);
        send_word(KIND_INSERT, 32'hAAAA_AAAA);
        send_word(KIND_INSERT, 32'h5555_5555);
        send_word(KIND_DELETE, 32'hAAAA_AAAA);
        send_word(KIND_DELETE, 32'h5555_5555);
        send_word(KIND_DELETE, 32'h0000_0000);
        send_word(KIND_DELETE, 32'hFFFF_FFFF);
        send_word(KIND_DELETE, 32'h0000_0005);
        send_word(KIND_DELETE, 32'h0000_0005);
        send_word(KIND_DELETE, 32'h0000_0005);
        wait_for_results();

        items_sent = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = (phase + 1) * RANDOM_ITEMS / 3;
            while (items_sent < target)
            begin
                random_run();
                if ($urandom_range(9) == 0)
                begin
                    wait_for_results();
                end
            end
            wait_for_results();
        end

        // Let any stray result word show up before the verdict.
        s_tvalid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("run covered %0d random items after the directed ones: %0d placed, %0d removed",
                 items_sent, placed_count, removed_count);
        $display("  %0d dropped on a full table, %0d delete misses, peak fill %0d of %0d",
                 full_count, missing_count, peak_fill, DEPTH);
        if (pending_count != 0)
        begin
            $display("%0d expected result words never arrived", pending_count);
        end
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/sti_pkg.sv
rtl/sti_cell.sv
rtl/sorted_table_insert_delete_top.sv
tb/sorted_table_checker.sv
tb/sorted_table_insert_delete_top_tb.sv
